// File: rtl/swh_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// swh_pkg
// Sizes, register indexes and shared types of the sliding window histogram.
// ============================================================================
package swh_pkg;

    // Window and histogram geometry
    localparam int WINDOW     = 1024;
    localparam int NUM_BINS   = 64;
    localparam int TOTAL_BINS = NUM_BINS + 2;

    localparam int RING_AW = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int BIN_W   = $clog2(TOTAL_BINS);
    localparam int OCC_W   = $clog2(NUM_BINS + 1);

    // Saturating counters (bin counts and window total)
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Sample and register widths
    localparam int AMP_W   = 16;
    localparam int SCALE_W = 32;
    localparam int PROD_W  = AMP_W + SCALE_W;
    localparam int FRAC_W  = 16;

    // Special bins
    localparam logic [BIN_W-1:0] UNDER_BIN = '0;
    localparam logic [BIN_W-1:0] OVER_BIN  = BIN_W'(NUM_BINS + 1);

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register reset values
    localparam logic [AMP_W-1:0]   RANGE_MIN_RST = '0;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RST = SCALE_W'(65536);

    // Register indexes (byte address bit 2)
    typedef enum logic {
        REG_RANGE_MIN = 1'b0,
        REG_BIN_SCALE = 1'b1
    } t_reg_idx;

    // Bin memory operation kinds
    typedef enum logic {
        OP_EVICT = 1'b0,
        OP_ADD   = 1'b1
    } t_op_kind;

    // One result item
    typedef struct packed {
        logic [OCC_W-1:0] nonempty_bins;
        logic [CNT_W-1:0] events_in_window;
        logic             evicted;
        logic [CNT_W-1:0] new_bin_count;
        logic [BIN_W-1:0] new_bin;
    } t_result;

endpackage

// File: rtl/sliding_window_histogram.sv
`timescale 1ns / 1ps
// ============================================================================
// sliding_window_histogram
// Histogram of the last WINDOW amplitudes, kept in a bin count memory that is
// updated by read-modify-write, with the samples held in a ring memory.
// ============================================================================
// Path: an accepted item passes stages 1, 2 and 3 and the modify stage into the result queue.
// Input: no item is taken while r_acc_last is set; the bin memory (one read, one write port)
//   takes one evict (full window only) and one add read-modify-write per item, one per cycle.
// Reset: synchronous, active low; clears the histogram at once via per-bin
//   valid bits, with no clearing pass. Ring contents stay undefined.
module sliding_window_histogram
    import swh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] amplitude
    // result item stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [6:0] new_bin, [17:7] new_bin_count,
                                         // [18] evicted, [29:19] events_in_window,
                                         // [36:30] nonempty_bins, [39:37] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [AMP_W-1:0]   r_range_min;
    logic [SCALE_W-1:0] r_bin_scale;

    logic [AMP_W-1:0]   ring [WINDOW];
    logic [RING_AW-1:0] r_wp;
    logic [FILL_W-1:0]  r_fill;
    logic               evict_now;

    logic               in_acc;
    logic               r_acc_last;
    logic [FIFO_CW-1:0] r_inflight;
    logic [FIFO_CW:0]   busy_sum;

    // stage 1: ring data and new sample
    logic               r_s1_vld;
    logic               r_s1_evict;
    logic [AMP_W-1:0]   r_s1_amp;
    logic [AMP_W-1:0]   r_ring_q;

    // stage 2: products
    logic               r_s2_vld;
    logic               r_s2_evict;
    logic [PROD_W-1:0]  r_s2_new_prod;
    logic               r_s2_new_neg;
    logic [PROD_W-1:0]  r_s2_old_prod;
    logic               r_s2_old_neg;
    logic [AMP_W:0]     d_new;
    logic [AMP_W:0]     d_old;
    logic [BIN_W-1:0]   new_bin_s2;
    logic [BIN_W-1:0]   old_bin_s2;

    // stage 3: add operation held behind the evict
    logic               r_s3_vld;
    logic               r_s3_evict;
    logic [BIN_W-1:0]   r_s3_bin;

    // bin memory operation, read and modify stages
    logic               op_vld;
    t_op_kind           op_kind;
    logic [BIN_W-1:0]   op_addr;
    logic               r_m_vld;
    t_op_kind           r_m_kind;
    logic [BIN_W-1:0]   r_m_addr;
    logic               r_m_evict;
    logic [CNT_W-1:0]   r_rd;
    logic [CNT_W-1:0]   bin_mem [TOTAL_BINS];
    logic [TOTAL_BINS-1:0] r_bin_valid;

    logic               r_fwd_vld;
    logic [BIN_W-1:0]   r_fwd_addr;
    logic [CNT_W-1:0]   r_fwd_val;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               m_in_range;

    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   n_total;
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic               push;
    t_result            push_res;

    // result queue
    t_result            fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_fifo_wp;
    logic [FIFO_AW-1:0] r_fifo_rp;
    logic [FIFO_CW-1:0] r_fifo_cnt;
    logic               pop;
    t_result            head;

    logic               cfg_wr;

    // ------------------------------------------------------------------
    // Binning from a registered product
    // ------------------------------------------------------------------
    function automatic logic [BIN_W-1:0] bin_of(input logic neg, input logic [PROD_W-1:0] prod);
        logic [PROD_W-FRAC_W-1:0] k;
        logic [BIN_W-1:0]         b;
        k = prod[PROD_W-1:FRAC_W];
        if (neg) begin
            b = UNDER_BIN;
        end else if (k >= (PROD_W-FRAC_W)'(NUM_BINS)) begin
            b = OVER_BIN;
        end else begin
            b = k[BIN_W-1:0] + BIN_W'(1);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= RANGE_MIN_RST;
            r_bin_scale <= BIN_SCALE_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_RANGE_MIN: r_range_min <= pwdata[AMP_W-1:0];
                REG_BIN_SCALE: r_bin_scale <= pwdata;
                default:       r_bin_scale <= r_bin_scale;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_RANGE_MIN: prdata = {{(32-AMP_W){r_range_min[AMP_W-1]}}, r_range_min};
            REG_BIN_SCALE: prdata = r_bin_scale;
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input acceptance: blocked while r_acc_last is set, only with room for the result
    // ------------------------------------------------------------------
    assign busy_sum        = {1'b0, r_inflight} + {1'b0, r_fifo_cnt};
    assign o_s_axis_tready = !r_acc_last && (busy_sum < (FIFO_CW+1)'(FIFO_DEPTH));
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign evict_now       = (r_fill == FILL_W'(WINDOW));

    // ring pointer, fill level and control valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_fill     <= '0;
            r_acc_last <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_m_vld    <= 1'b0;
        end else begin
            r_acc_last <= in_acc;
            r_s1_vld   <= in_acc;
            r_s2_vld   <= r_s1_vld;
            r_s3_vld   <= r_s2_vld;
            r_m_vld    <= op_vld;
            if (in_acc) begin
                r_wp <= (r_wp == RING_AW'(WINDOW - 1)) ? '0 : r_wp + RING_AW'(1);
                if (!evict_now) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // ring memory: read the oldest sample, then overwrite it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            ring[r_wp] <= i_s_axis_tdata;
        end
        r_ring_q <= ring[r_wp];
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: offsets and products
    // ------------------------------------------------------------------
    assign d_new = {r_s1_amp[AMP_W-1], r_s1_amp} - {r_range_min[AMP_W-1], r_range_min};
    assign d_old = {r_ring_q[AMP_W-1], r_ring_q} - {r_range_min[AMP_W-1], r_range_min};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_amp   <= i_s_axis_tdata;
            r_s1_evict <= evict_now;
        end
        r_s2_evict    <= r_s1_evict;
        r_s2_new_neg  <= d_new[AMP_W];
        r_s2_new_prod <= PROD_W'(d_new[AMP_W-1:0]) * PROD_W'(r_bin_scale);
        r_s2_old_neg  <= d_old[AMP_W];
        r_s2_old_prod <= PROD_W'(d_old[AMP_W-1:0]) * PROD_W'(r_bin_scale);
    end

    // ------------------------------------------------------------------
    // Stage 2: bins; issue evict now, add from the stage 3 register later
    // ------------------------------------------------------------------
    assign new_bin_s2 = bin_of(r_s2_new_neg, r_s2_new_prod);
    assign old_bin_s2 = bin_of(r_s2_old_neg, r_s2_old_prod);

    always_ff @(posedge i_clk) begin
        r_s3_bin   <= new_bin_s2;
        r_s3_evict <= r_s2_evict;
    end

    // stage 2 and stage 3 never hold items together
    always_comb begin
        if (r_s3_vld) begin
            op_vld  = 1'b1;
            op_kind = OP_ADD;
            op_addr = r_s3_bin;
        end else begin
            op_vld  = r_s2_vld & r_s2_evict;
            op_kind = OP_EVICT;
            op_addr = old_bin_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_kind  <= op_kind;
        r_m_addr  <= op_addr;
        r_m_evict <= r_s3_evict;
    end

    // ------------------------------------------------------------------
    // Modify stage: forward the write of the previous cycle
    // ------------------------------------------------------------------
    assign m_in_range = (r_m_addr != UNDER_BIN) && (r_m_addr != OVER_BIN);

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_m_addr)) begin
            cur_cnt = r_fwd_val;
        end else if (r_bin_valid[r_m_addr]) begin
            cur_cnt = r_rd;
        end else begin
            cur_cnt = '0;
        end
    end

    always_comb begin
        n_cnt   = cur_cnt;
        n_total = r_total;
        n_occ   = r_occ;
        push    = 1'b0;
        if (r_m_vld) begin
            case (r_m_kind)
                OP_EVICT: begin
                    if (cur_cnt != '0) begin
                        n_cnt = cur_cnt - CNT_W'(1);
                    end
                    if ((cur_cnt == CNT_W'(1)) && m_in_range && (r_occ != '0)) begin
                        n_occ = r_occ - OCC_W'(1);
                    end
                    if (r_total != '0) begin
                        n_total = r_total - CNT_W'(1);
                    end
                end
                OP_ADD: begin
                    push = 1'b1;
                    if (cur_cnt != CNT_MAX) begin
                        n_cnt = cur_cnt + CNT_W'(1);
                    end
                    if ((cur_cnt == '0) && m_in_range) begin
                        n_occ = r_occ + OCC_W'(1);
                    end
                    if (r_total != CNT_MAX) begin
                        n_total = r_total + CNT_W'(1);
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    assign push_res.new_bin          = r_m_addr;
    assign push_res.new_bin_count    = n_cnt;
    assign push_res.evicted          = r_m_evict;
    assign push_res.events_in_window = n_total;
    assign push_res.nonempty_bins    = n_occ;

    // bin count memory: registered read, write back from the modify stage
    always_ff @(posedge i_clk) begin
        if (r_m_vld) begin
            bin_mem[r_m_addr] <= n_cnt;
        end
        r_rd <= bin_mem[op_addr];
    end

    // valid bits, forwarding, totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid <= '0;
            r_fwd_vld   <= 1'b0;
            r_total     <= '0;
            r_occ       <= '0;
        end else begin
            r_fwd_vld <= r_m_vld;
            r_total   <= n_total;
            r_occ     <= n_occ;
            if (r_m_vld) begin
                r_bin_valid[r_m_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_m_addr;
        r_fwd_val  <= n_cnt;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign head            = fifo[r_fifo_rp];
    assign o_m_axis_tvalid = (r_fifo_cnt != '0);
    assign pop             = o_m_axis_tvalid & i_m_axis_tready;
    assign o_m_axis_tdata  = {3'b000, head.nonempty_bins, head.events_in_window,
                              head.evicted, head.new_bin_count, head.new_bin};

    always_ff @(posedge i_clk) begin
        if (push) begin
            fifo[r_fifo_wp] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_wp  <= '0;
            r_fifo_rp  <= '0;
            r_fifo_cnt <= '0;
            r_inflight <= '0;
        end else begin
            if (push) begin
                r_fifo_wp <= r_fifo_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_fifo_rp <= r_fifo_rp + FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(push) - FIFO_CW'(pop);
            r_inflight <= r_inflight + FIFO_CW'(in_acc) - FIFO_CW'(push);
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives amplitude items into the sliding window histogram under random
// backpressure and register changes, tracks the window and bin counts on
// the side, and compares every result item field by field in order.
// ============================================================================
module testbench;
    import swh_pkg::*;

    localparam int RES_W     = $bits(t_result);
    localparam int LONG_HOLD = 300;
    localparam int MAX_SHOWN = 40;

    // ------------------------------------------------------------------------
    // Window tracker: ring of amplitudes, bin counts and the results they owe
    // ------------------------------------------------------------------------
    class window_histogram_tracker;
        logic [AMP_W-1:0]   range_min;
        logic [SCALE_W-1:0] bin_scale;
        logic [AMP_W-1:0]   ring [WINDOW];
        int unsigned        wr_ptr;
        int unsigned        fill;
        int unsigned        bin_cnt [TOTAL_BINS];
        int unsigned        total;
        int unsigned        occupied;
        t_result            owed_results [$];
        int                 errors;
        int                 compared;
        int                 evictions;

        function void clear();
            range_min = RANGE_MIN_RST;
            bin_scale = BIN_SCALE_RST;
            wr_ptr    = 0;
            fill      = 0;
            total     = 0;
            occupied  = 0;
            foreach (bin_cnt[b]) bin_cnt[b] = 0;
            owed_results.delete();
            errors    = 0;
            compared  = 0;
            evictions = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            if (idx == REG_RANGE_MIN) begin
                range_min = value[AMP_W-1:0];
            end else begin
                bin_scale = value;
            end
        endfunction

        // Uniform binning from range_min with a Q16 bins-per-unit scale
        function int unsigned bin_of(logic [AMP_W-1:0] amp);
            int         d;
            logic [63:0] k;
            d = int'($signed(amp)) - int'($signed(range_min));
            if (d < 0) return 0;
            k = (64'(d) * 64'(bin_scale)) >> FRAC_W;
            if (k >= 64'(NUM_BINS)) return NUM_BINS + 1;
            return int'(k) + 1;
        endfunction

        function bit in_range(int unsigned b);
            return b >= 1 && b <= NUM_BINS;
        endfunction

        // Evict the oldest amplitude once the window is full, then count the new one
        function void note_amplitude(logic [AMP_W-1:0] amp);
            t_result     r;
            int unsigned old_bin;
            int unsigned nb;
            bit          evict;
            evict = fill >= WINDOW;
            if (evict) begin
                old_bin = bin_of(ring[wr_ptr]);
                if (bin_cnt[old_bin] > 0) begin
                    bin_cnt[old_bin]--;
                    if (bin_cnt[old_bin] == 0 && in_range(old_bin) && occupied > 0)
                        occupied--;
                end
                if (total > 0) total--;
                evictions++;
            end else begin
                fill++;
            end
            ring[wr_ptr] = amp;
            wr_ptr = (wr_ptr + 1) % WINDOW;

            nb = bin_of(amp);
            if (bin_cnt[nb] < CNT_MAX) begin
                bin_cnt[nb]++;
                if (bin_cnt[nb] == 1 && in_range(nb)) occupied++;
            end
            if (total < CNT_MAX) total++;

            r.new_bin          = BIN_W'(nb);
            r.new_bin_count    = CNT_W'(bin_cnt[nb]);
            r.evicted          = evict;
            r.events_in_window = CNT_W'(total);
            r.nonempty_bins    = OCC_W'(occupied);
            owed_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
        endtask

        // Compare one result item against the oldest owed result
        task check_result(logic [39:0] data);
            t_result got;
            t_result want;
            got = data[RES_W-1:0];
            if (owed_results.size() == 0) begin
                report($sformatf("result item %h with nothing owed", data));
                return;
            end
            want = owed_results.pop_front();
            compared++;
            if (got.new_bin != want.new_bin)
                report($sformatf("item %0d new_bin %0d, want %0d",
                                 compared, got.new_bin, want.new_bin));
            if (got.new_bin_count != want.new_bin_count)
                report($sformatf("item %0d new_bin_count %0d, want %0d",
                                 compared, got.new_bin_count, want.new_bin_count));
            if (got.evicted != want.evicted)
                report($sformatf("item %0d evicted %0d, want %0d",
                                 compared, got.evicted, want.evicted));
            if (got.events_in_window != want.events_in_window)
                report($sformatf("item %0d events_in_window %0d, want %0d",
                                 compared, got.events_in_window, want.events_in_window));
            if (got.nonempty_bins != want.nonempty_bins)
                report($sformatf("item %0d nonempty_bins %0d, want %0d",
                                 compared, got.nonempty_bins, want.nonempty_bins));
            if (data[39:RES_W] != '0)
                report($sformatf("item %0d pad bits %b", compared, data[39:RES_W]));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [15:0] i_s_axis_tdata  = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;
    logic [31:0] prdata;
    logic        pready;

    sliding_window_histogram i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    window_histogram_tracker tracker;
    bit          rx_steady    = 1'b0;
    bit          hold_req     = 1'b0;
    int          stall_left   = 0;
    int unsigned rx_roll;
    int          items_sent   = 0;
    int          settings_run = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("run limit reached with %0d results still owed",
                 tracker.owed_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check accepted items, then pick tready for the next edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata);
        if (hold_req) begin
            stall_left = LONG_HOLD;
            hold_req   = 1'b0;
        end
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (rx_steady) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 65) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and register port
    // ------------------------------------------------------------------------
    task send_amplitude(logic [15:0] amp);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= amp;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.note_amplitude(amp);
        items_sent++;
    endtask

    // Drop tvalid for a random gap, often none, mostly short, now and then long
    task idle_sender();
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input until every owed result has come back
    task drain();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
    endtask

    task write_register(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        // idle the bus before the next transfer
        @(posedge i_clk);
    endtask

    // Mostly inside the band of interest, some full-range noise, some edges
    function logic [15:0] pick_amplitude(int lo, int hi);
        int unsigned roll;
        int          v;
        int          rmin;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        rmin = int'($signed(tracker.range_min));
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            v = lo + int'($urandom_range(0, hi - lo));
        end else if (roll < 88) begin
            v = int'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = rmin;
                default: v = rmin - 1;
            endcase
        end
        return 16'(v);
    endfunction

    task run_setting(int rmin, logic [31:0] scale, int lo, int hi, int count,
                     bit steady, bit hold);
        drain();
        write_register(REG_RANGE_MIN, 32'(rmin));
        write_register(REG_BIN_SCALE, scale);
        rx_steady = steady;
        if (hold) hold_req = 1'b1;
        for (int n = 0; n < count; n++) begin
            send_amplitude(pick_amplitude(lo, hi));
            if (!steady) idle_sender();
        end
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] edge_amps [$];
        tracker = new();
        tracker.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: amplitude a in 0..63 lands in bin a+1
        edge_amps = '{16'h0000, 16'h0001, 16'd63, 16'd64, 16'hFFFF, 16'h8000,
                      16'h7FFF, 16'h5555, 16'hAAAA, 16'd5, 16'd5, 16'd5,
                      16'd62, 16'd62, 16'hFFFE, 16'd100, 16'h0000, 16'h0001,
                      16'h7FFE, 16'h8001, 16'd2, 16'd3, 16'd63, 16'hFFFF, 16'd64};
        foreach (edge_amps[i]) begin
            send_amplitude(edge_amps[i]);
            idle_sender();
        end
        settings_run++;

        // Spread bins, then register extremes, then a narrow band under a long hold, then full range
        run_setting(-1024, 32'd2048, -1100, 1100, 180, 1'b0, 1'b0);
        run_setting(32767, 32'hFFFF_FFFF, 32700, 32767, 100, 1'b1, 1'b0);
        run_setting(-32768, 32'd0, -32768, -32000, 80, 1'b0, 1'b0);
        run_setting(100, 32'h0004_0000, 90, 120, 180, 1'b0, 1'b1);
        run_setting(-32768, 32'd64, -32768, 32767, 250, 1'b0, 1'b0);
        // Window fills in the last setting; evicted samples get rebinned with new registers
        run_setting(-512, 32'd4096, -600, 600, 200, 1'b0, 1'b0);
        run_setting(0, BIN_SCALE_RST, -10, 80, 150, 1'b0, 1'b0);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d amplitude items over %0d register settings, %0d with eviction",
                 items_sent, settings_run, tracker.evictions);
        $display("Compared %0d result items, %0d mismatches",
                 tracker.compared, tracker.errors);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
